// ===== design/vrd_pkg.sv =====
// Package for the vitals record decoder: payload structs, type and item codes,
// and the scale factors that turn raw readings into hundredths. No dependencies.
package vrd_pkg;

    localparam logic [7:0]  HEADER_BYTE  = 8'h51;
    localparam logic [15:0] BAD_VALUE_A  = 16'hFFFF;
    localparam logic [15:0] BAD_VALUE_B  = 16'h00FF;
    localparam logic [3:0]  FULL_LENGTH  = 4'd8;
    localparam logic [3:0]  OXI_LENGTH   = 4'd6;
    localparam logic [3:0]  TEMP_LENGTH  = 4'd4;

    localparam logic [1:0]  KIND_OXIMETER = 2'd0;
    localparam logic [1:0]  KIND_BP_GLU   = 2'd1;
    localparam logic [1:0]  KIND_THERMO   = 2'd2;
    localparam logic [1:0]  KIND_SIX      = 2'd3;

    localparam logic [1:0]  MODE_NORMAL  = 2'd0;
    localparam logic [1:0]  MODE_CONTROL = 2'd3;

    localparam logic [3:0]  VT_GLUCOSE     = 4'd0;
    localparam logic [3:0]  VT_SYSTOLIC    = 4'd1;
    localparam logic [3:0]  VT_DIASTOLIC   = 4'd2;
    localparam logic [3:0]  VT_PULSE       = 4'd3;
    localparam logic [3:0]  VT_HCT         = 4'd4;
    localparam logic [3:0]  VT_KETONE      = 4'd5;
    localparam logic [3:0]  VT_URIC        = 4'd6;
    localparam logic [3:0]  VT_CHOLESTEROL = 4'd7;
    localparam logic [3:0]  VT_HEMOGLOBIN  = 4'd8;
    localparam logic [3:0]  VT_SPO2        = 4'd9;
    localparam logic [3:0]  VT_TEMPERATURE = 4'd10;

    localparam logic [3:0]  ITEM_GLUCOSE     = 4'd0;
    localparam logic [3:0]  ITEM_HCT         = 4'd6;
    localparam logic [3:0]  ITEM_KETONE      = 4'd7;
    localparam logic [3:0]  ITEM_URIC        = 4'd8;
    localparam logic [3:0]  ITEM_CHOLESTEROL = 4'd9;
    localparam logic [3:0]  ITEM_HEMOGLOBIN  = 4'd11;

    localparam logic [6:0]  FACTOR_WHOLE = 7'd100;
    localparam logic [6:0]  FACTOR_HGB   = 7'd34;
    localparam logic [6:0]  FACTOR_TENTH = 7'd10;

    localparam int SLOTS = 3;

    typedef struct packed {
        logic [1:0] device_kind;
        logic [3:0] record_length;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
        logic [7:0] byte_seven;
    } t_record;

    typedef struct packed {
        logic [3:0]  vital_type;
        logic [22:0] value_hundredths;
        logic [26:0] time_key;
        logic [1:0]  echo_kind;
        logic [1:0]  measure_mode;
        logic        last_reading;
    } t_vital;

    typedef struct packed {
        logic [1:0]              cnt;
        logic [SLOTS-1:0][3:0]   vtype;
        logic [SLOTS-1:0][15:0]  raw;
        logic [SLOTS-1:0][6:0]   factor;
        logic [26:0]             key;
        logic [1:0]              kind;
        logic [1:0]              mode;
    } t_dec;

    typedef struct packed {
        logic [1:0]              cnt;
        logic [SLOTS-1:0][3:0]   vtype;
        logic [SLOTS-1:0][22:0]  value;
        logic [26:0]             key;
        logic [1:0]              kind;
        logic [1:0]              mode;
    } t_calc;

endpackage

// ===== design/vrd_if.sv =====
// Channel interfaces of the vitals record decoder: one carries a record word in,
// the other a reading word out. Depends on vrd_pkg for the payload structs.
interface vrd_rec_if;
    logic             valid;
    logic             ready;
    vrd_pkg::t_record data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vrd_vital_if;
    logic            valid;
    logic            ready;
    vrd_pkg::t_vital data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/vitals_record_decoder_unit.sv =====
// Top level of the vitals record decoder: decode, scale and serializer stages.
// Depends on vrd_pkg and on the channel interfaces in vrd_if.sv.
//
// Usage: a record word (device kind, length, eight bytes) enters on i_rec and
// zero to three reading words leave on o_vital, one per cycle while o_vital
// is ready, the final one of each record flagged by last_reading. Records
// that yield no reading vanish. A record passes from acceptance to o_vital
// through the decode register, scaling multiplier register, serializer and
// output register. A record can be accepted in every cycle while i_rec.ready
// is high; sustained throughput is set by the serializer, which holds each
// record, taking no other, until its last reading has moved on.
// Synchronous reset clears all valid bits; no word is in flight afterwards.
// When o_vital stalls, every stage holds its word; i_rec.ready falls in the
// same cycle once every stage ahead holds a word, while an empty stage still
// takes one. Nothing is lost or repeated.
module vitals_record_decoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vrd_rec_if.sink         i_rec,
    vrd_vital_if.source     o_vital
);
    import vrd_pkg::*;

    t_dec        n_dec;
    t_dec        r_a;
    logic        r_a_vld;
    t_calc       n_calc;
    t_calc       r_b;
    logic        r_b_vld;
    t_calc       r_c;
    logic        r_c_vld;
    logic [1:0]  r_c_idx;
    t_vital      n_out;
    t_vital      r_o;
    logic        r_o_vld;

    logic        o_free;
    logic        c_adv;
    logic        c_last;
    logic        c_free;
    logic        b_free;
    logic        a_free;

    t_record     rec;
    logic [15:0] raw16;
    logic [15:0] raw12;
    logic [1:0]  mode;
    logic [3:0]  item;
    logic [26:0] key;
    logic        raw_bad;

    assign o_free  = !r_o_vld || o_vital.ready;
    assign c_adv   = r_c_vld && o_free;
    assign c_last  = r_c_idx == (r_c.cnt - 2'd1);
    assign c_free  = !r_c_vld || (c_adv && c_last);
    assign b_free  = !r_b_vld || c_free;
    assign a_free  = !r_a_vld || b_free;

    assign i_rec.ready   = a_free;
    assign o_vital.valid = r_o_vld;
    assign o_vital.data  = r_o;

    assign rec     = i_rec.data;
    assign raw16   = {rec.byte_five, rec.byte_four};
    assign raw12   = {4'd0, rec.byte_three[3:0], rec.byte_two};
    assign mode    = rec.byte_seven[7:6];
    assign item    = rec.byte_seven[5:2];
    assign key     = {rec.byte_one[7:1], rec.byte_one[0], rec.byte_zero[7:5],
                      rec.byte_zero[4:0], rec.byte_three[4:0], rec.byte_two[5:0]};
    assign raw_bad = (raw16 == BAD_VALUE_A) || (raw16 == BAD_VALUE_B);

    always_comb begin
        n_dec        = '0;
        n_dec.kind   = rec.device_kind;
        n_dec.factor = {FACTOR_WHOLE, FACTOR_WHOLE, FACTOR_WHOLE};
        case (rec.device_kind)
            KIND_BP_GLU: begin
                n_dec.key = key;
                if (rec.record_length >= FULL_LENGTH) begin
                    if (!rec.byte_two[7]) begin
                        if (!raw_bad && mode != MODE_CONTROL) begin
                            n_dec.cnt      = 2'd1;
                            n_dec.mode     = mode;
                            n_dec.vtype[0] = VT_GLUCOSE;
                            n_dec.raw[0]   = raw16;
                        end
                    end else begin
                        n_dec.cnt      = 2'd3;
                        n_dec.mode     = MODE_NORMAL;
                        n_dec.vtype[0] = VT_SYSTOLIC;
                        n_dec.vtype[1] = VT_DIASTOLIC;
                        n_dec.vtype[2] = VT_PULSE;
                        n_dec.raw[0]   = {8'd0, rec.byte_four};
                        n_dec.raw[1]   = {8'd0, rec.byte_six};
                        n_dec.raw[2]   = {8'd0, rec.byte_seven};
                    end
                end
            end
            KIND_SIX: begin
                n_dec.key       = key;
                n_dec.mode      = mode;
                n_dec.raw[0]    = raw16;
                n_dec.raw[1]    = raw16;
                n_dec.factor[1] = FACTOR_HGB;
                n_dec.vtype[1]  = VT_HEMOGLOBIN;
                if (rec.record_length >= FULL_LENGTH && !raw_bad) begin
                    case (item)
                        ITEM_GLUCOSE: begin
                            n_dec.vtype[0] = VT_GLUCOSE;
                            n_dec.cnt      = (mode == MODE_CONTROL) ? 2'd0 : 2'd1;
                        end
                        ITEM_HCT: begin
                            n_dec.vtype[0] = VT_HCT;
                            n_dec.cnt      = 2'd2;
                        end
                        ITEM_KETONE: begin
                            n_dec.vtype[0] = VT_KETONE;
                            n_dec.cnt      = 2'd1;
                        end
                        ITEM_URIC: begin
                            n_dec.vtype[0] = VT_URIC;
                            n_dec.cnt      = 2'd1;
                        end
                        ITEM_CHOLESTEROL: begin
                            n_dec.vtype[0] = VT_CHOLESTEROL;
                            n_dec.cnt      = 2'd1;
                        end
                        ITEM_HEMOGLOBIN: begin
                            n_dec.vtype[0] = VT_HEMOGLOBIN;
                            n_dec.cnt      = 2'd1;
                        end
                        default: begin
                            n_dec.cnt = 2'd0;
                        end
                    endcase
                end
            end
            KIND_OXIMETER: begin
                n_dec.vtype[0] = VT_SPO2;
                n_dec.vtype[1] = VT_PULSE;
                n_dec.raw[0]   = raw12;
                n_dec.raw[1]   = {8'd0, rec.byte_five};
                if (rec.record_length >= OXI_LENGTH && rec.byte_zero == HEADER_BYTE) begin
                    n_dec.cnt = 2'd2;
                end
            end
            default: begin
                n_dec.vtype[0]  = VT_TEMPERATURE;
                n_dec.raw[0]    = raw12;
                n_dec.factor[0] = FACTOR_TENTH;
                if (rec.record_length >= TEMP_LENGTH && rec.byte_zero == HEADER_BYTE) begin
                    n_dec.cnt = 2'd1;
                end
            end
        endcase
    end

    always_comb begin
        n_calc.cnt   = r_a.cnt;
        n_calc.vtype = r_a.vtype;
        n_calc.key   = r_a.key;
        n_calc.kind  = r_a.kind;
        n_calc.mode  = r_a.mode;
        for (int s = 0; s < SLOTS; s++) begin
            n_calc.value[s] = 23'(r_a.raw[s]) * 23'(r_a.factor[s]);
        end
    end

    always_comb begin
        n_out.vital_type       = r_c.vtype[r_c_idx];
        n_out.value_hundredths = r_c.value[r_c_idx];
        n_out.time_key         = r_c.key;
        n_out.echo_kind        = r_c.kind;
        n_out.measure_mode     = r_c.mode;
        n_out.last_reading     = c_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_c_idx <= 2'd0;
            r_o_vld <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_vld <= i_rec.valid && (n_dec.cnt != 2'd0);
            end
            if (b_free) begin
                r_b_vld <= r_a_vld;
            end
            if (c_free) begin
                r_c_vld <= r_b_vld;
                r_c_idx <= 2'd0;
            end else if (c_adv) begin
                r_c_idx <= r_c_idx + 2'd1;
            end
            if (o_free) begin
                r_o_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a <= n_dec;
        end
        if (b_free) begin
            r_b <= n_calc;
        end
        if (c_free) begin
            r_c <= r_b;
        end
        if (o_free) begin
            r_o <= n_out;
        end
    end

    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> r_a.cnt != 2'd0)
        else $error("Decode stage holds a record without readings.");

    a_ser_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> (r_c.cnt != 2'd0) && (r_c_idx < r_c.cnt))
        else $error("Serializer index runs past the reading count.");

    a_ser_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld && !o_free |=> r_c_vld && $stable(r_c_idx))
        else $error("Serializer moved while the output register was full.");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_adv && !c_last |=> r_c_vld && r_c_idx == $past(r_c_idx) + 2'd1)
        else $error("Serializer dropped a record before its last reading.");

endmodule
